[hdl/b64e_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // Default number of full quartets on one output line.
  localparam int unsigned QUARTETS_PER_LINE_DEF = 19;
  // Default depth of the group queue between front and back.
  localparam int unsigned GROUP_FIFO_DEPTH_DEF = 4;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Character slots of one group record, in output order.
  localparam logic [2:0] SLOT_C0 = 3'd0;
  localparam logic [2:0] SLOT_C1 = 3'd1;
  localparam logic [2:0] SLOT_C2 = 3'd2;
  localparam logic [2:0] SLOT_C3 = 3'd3;
  localparam logic [2:0] SLOT_CR = 3'd4;
  localparam logic [2:0] SLOT_LF = 3'd5;

  // How many message bytes a group carries.
  typedef enum logic [1:0] {
    GRP_ONE  = 2'd0,
    GRP_TWO  = 2'd1,
    GRP_FULL = 2'd2
  } grp_kind_e;

  // One group as handed from the front to the back.
  typedef struct packed {
    logic [23:0] bits;
    grp_kind_e   kind;
    logic        crlf;
    logic        last;
  } grp_rec_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] v;
    v = {2'b00, sextet};
    if (v < 8'd26) begin
      return v + 8'd65;
    end else if (v < 8'd52) begin
      return v + 8'd71;
    end else if (v < 8'd62) begin
      return v - 8'd4;
    end else if (v == 8'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

[hdl/b64e_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64e_front import b64e_pkg::*; #(
  parameter int unsigned QUARTETS_PER_LINE = QUARTETS_PER_LINE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_final_i,
  output logic            push_o,
  output grp_rec_t        push_rec_o,
  input  wire logic       fifo_full_i
);

  localparam int unsigned LINE_W = $clog2(QUARTETS_PER_LINE + 1);

  logic              wrap_q;
  logic [15:0]       pend_q, pend_d;
  logic [1:0]        have_q, have_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [LINE_W-1:0] line_inc;
  logic              accept;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign line_inc   = line_q + LINE_W'(1);

  always_comb begin
    pend_d     = pend_q;
    have_d     = have_q;
    line_d     = line_q;
    push_o     = 1'b0;
    push_rec_o = '{bits: {in_byte_i, 16'h0000}, kind: GRP_ONE, crlf: 1'b0,
                   last: in_final_i};
    if (accept) begin
      if (have_q < 2'd2 && !in_final_i) begin
        // The group is still filling.
        if (have_q == 2'd0) begin
          pend_d = {in_byte_i, 8'h00};
        end else begin
          pend_d = {pend_q[15:8], in_byte_i};
        end
        have_d = have_q + 2'd1;
      end else begin
        push_o = 1'b1;
        if (have_q == 2'd1) begin
          push_rec_o.bits = {pend_q[15:8], in_byte_i, 8'h00};
          push_rec_o.kind = GRP_TWO;
        end else if (have_q == 2'd2) begin
          push_rec_o.bits = {pend_q, in_byte_i};
          push_rec_o.kind = GRP_FULL;
          if (line_inc >= LINE_W'(QUARTETS_PER_LINE)) begin
            line_d          = '0;
            push_rec_o.crlf = wrap_q;
          end else begin
            line_d = line_inc;
          end
        end
        have_d = 2'd0;
        if (in_final_i) begin
          line_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
      have_q <= 2'd0;
      line_q <= '0;
    end else begin
      if (cfg_we_i) begin
        wrap_q <= cfg_wdata_i;
      end
      have_q <= have_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

[hdl/b64e_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64e_fifo import b64e_pkg::*; #(
  parameter int unsigned DEPTH = GROUP_FIFO_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  grp_rec_t  push_rec_i,
  output logic      full_o,
  input  wire logic pop_i,
  output grp_rec_t  pop_rec_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  grp_rec_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end else begin
      return p + PTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

`default_nettype wire

[hdl/b64e_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64e_back import b64e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  grp_rec_t        pop_rec_i,
  input  wire logic       fifo_empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);

  grp_rec_t   cur_q;
  logic       cur_valid_q;
  logic [2:0] slot_q;
  logic       m_valid_q;
  logic [7:0] m_char_q;
  logic       m_last_q;

  logic       out_free, emit, done;
  logic [2:0] end_slot;
  logic [7:0] char_d;

  assign out_free = !m_valid_q || out_ready_i;
  assign emit     = cur_valid_q && out_free;
  assign end_slot = cur_q.crlf ? SLOT_LF : SLOT_C3;
  assign done     = (slot_q == end_slot);
  assign pop_o    = (!cur_valid_q || (emit && done)) && !fifo_empty_i;

  always_comb begin
    unique case (slot_q)
      SLOT_C0: char_d = b64_char(cur_q.bits[23:18]);
      SLOT_C1: char_d = b64_char(cur_q.bits[17:12]);
      SLOT_C2: char_d = (cur_q.kind == GRP_ONE) ? CHAR_PAD : b64_char(cur_q.bits[11:6]);
      SLOT_C3: char_d = (cur_q.kind == GRP_FULL) ? b64_char(cur_q.bits[5:0]) : CHAR_PAD;
      SLOT_CR: char_d = CHAR_CR;
      SLOT_LF: char_d = CHAR_LF;
      default: char_d = CHAR_PAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      slot_q      <= SLOT_C0;
      m_valid_q   <= 1'b0;
    end else begin
      if (emit) begin
        slot_q <= done ? SLOT_C0 : slot_q + 3'd1;
      end
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (emit && done) begin
        cur_valid_q <= 1'b0;
      end
      if (out_free) begin
        m_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_rec_i;
    end
    if (emit) begin
      m_char_q <= char_d;
      m_last_q <= cur_q.last && done;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_char_o  = m_char_q;
  assign out_last_o  = m_last_q;

`ifndef NO_ASSERTIONS
  a_crlf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && cur_q.crlf |-> cur_q.kind == GRP_FULL)
    else $error("line break requested on a padded group");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !cur_q.crlf |-> slot_q <= SLOT_C3)
    else $error("character slot beyond the quartet without line break");
  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> slot_q == SLOT_C0)
    else $error("character slot advanced with no group held");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !out_ready_i |=> m_valid_q && $stable(m_char_q))
    else $error("output register changed while stalled");
`endif

endmodule

`default_nettype wire

[hdl/base64_stream_encoder.sv]
// Streaming Base64 encoder with optional CR LF line wrapping.
// The slave channel takes one raw message byte per transfer in tdata; tlast
// marks the last byte of a message. The master channel gives one ASCII
// character per transfer in tdata (alphabet character, '=', CR or LF), and
// tlast marks the final character of the message.
// Every third byte, or the byte marked last, closes a group. A group yields
// four characters, padded with '=' when the message ends short, and a full
// quartet that completes a line is followed by CR LF when wrap_enable is set.
// The first character of a group passes through the group queue, the held
// group register and the output register. The output side moves one
// character per cycle while the receiver is ready and groups are queued; the
// input side keeps taking bytes as long as the group queue has room.
// The wrap_enable register is written through cfg_we_i and cfg_wdata_i and
// should only change while no message is in flight.
// Reset empties the queue, drops pending bytes, clears the line counter and
// turns wrapping off. When the receiver stalls, the current character holds
// in the output register; the queue then fills and s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned QUARTETS_PER_LINE = QUARTETS_PER_LINE_DEF,
  parameter int unsigned GROUP_FIFO_DEPTH  = GROUP_FIFO_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,     // wrap_enable
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // data_byte[7:0]
  input  wire logic       s_axis_tlast,    // final_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // out_char[7:0]
  output logic            m_axis_tlast     // out_last
);

  grp_rec_t push_rec, pop_rec;
  logic     push, pop, fifo_full, fifo_empty;

  // Front end: collects bytes into groups and decides padding and breaks.
  b64e_front #(
    .QUARTETS_PER_LINE(QUARTETS_PER_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_final_i  (s_axis_tlast),
    .push_o      (push),
    .push_rec_o  (push_rec),
    .fifo_full_i (fifo_full)
  );

  // Group queue lets the byte side and the character side stall separately.
  b64e_fifo #(
    .DEPTH(GROUP_FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .empty_o    (fifo_empty)
  );

  // Back end: turns each group into its characters, one per cycle unless the receiver stalls.
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_rec_i    (pop_rec),
    .fifo_empty_i (fifo_empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

[dv/tb_base64_stream_encoder.sv]
`timescale 1ns / 1ps

// Self-checking bench for the streaming Base64 encoder.
// Whole messages are queued from the stimulus block, and a clocked driver
// presents them on the slave channel. A clocked monitor takes the characters
// from the master channel and compares each transfer with the oldest
// character that the encoding model has predicted.
module tb_base64_stream_encoder;
  import b64e_pkg::*;

  // Full quartets per output line, as the block is built by default.
  localparam int unsigned LINE_QUARTETS = QUARTETS_PER_LINE_DEF;
  // Pause that drain gives the block once every character is out, before
  // any register write or the end.
  localparam int unsigned SETTLE_CYCLES = 12;
  // The longest quiet stretch in a correct run is a drawn sender gap or a
  // drawn receiver stall plus the pipeline and the settle pause. The limit
  // lies far above that.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 42;

  // Alphabet in sextet order; character 0 sits in the top byte.
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Sender and receiver behavior, chosen per phase.
  typedef enum int {
    PACE_NONE,
    PACE_RANDOM,
    PACE_SPARSE
  } pace_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  raw_byte_t bytes_to_send[$];
  enc_char_t expected_chars[$];

  // Encoder state as the bench models it.
  logic [15:0] held_bytes = 16'h0000;
  logic [1:0]  held_count = 2'd0;
  logic [4:0]  line_quartets = 5'd0;
  logic        wrap_copy = 1'b0;

  pace_e pace = PACE_RANDOM;
  int    send_gap = 0;
  int    recv_stall = 0;
  int    idle_cycles = 0;
  int    errors = 0;
  int    bytes_sent = 0;
  int    msgs_sent = 0;
  int    chars_checked = 0;
  int    line_breaks = 0;
  int    full_lines_wrapped = 0;

  always #6 clk_i = ~clk_i;

  base64_stream_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // data_byte[7:0]
    .s_axis_tlast  (s_axis_tlast),    // final_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // out_char[7:0]
    .m_axis_tlast  (m_axis_tlast)     // out_last
  );

  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    return ALPHABET[8*(63 - idx) +: 8];
  endfunction

  // Number of idle cycles before the next item on either side.
  function automatic int draw_wait();
    case (pace)
      PACE_NONE:   return 0;
      PACE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  // Folds one accepted byte into the model. A byte that closes a group (the
  // third one, or any byte marked last) yields four characters, and a full
  // quartet that completes a line adds CR LF when wrapping is on.
  task automatic encode_byte(input logic [7:0] data, input logic fin);
    logic [23:0] grp;
    logic [7:0]  chars[6];
    int          n;
    n = 0;
    if (held_count < 2 && !fin) begin
      if (held_count == 0) begin
        held_bytes = {data, 8'h00};
      end else begin
        held_bytes[7:0] = data;
      end
      held_count = held_count + 2'd1;
    end else begin
      case (held_count)
        2'd0:    grp = {data, 16'h0000};
        2'd1:    grp = {held_bytes[15:8], data, 8'h00};
        default: grp = {held_bytes, data};
      endcase
      chars[0] = sextet_char(grp[23:18]);
      chars[1] = sextet_char(grp[17:12]);
      if (held_count == 2'd0) begin
        // A lone byte: two characters and two pad marks.
        chars[2] = CHAR_PAD;
        chars[3] = CHAR_PAD;
        n = 4;
      end else if (held_count == 2'd1) begin
        chars[2] = sextet_char(grp[11:6]);
        chars[3] = CHAR_PAD;
        n = 4;
      end else begin
        chars[2] = sextet_char(grp[11:6]);
        chars[3] = sextet_char(grp[5:0]);
        n = 4;
        // The line counter runs whether or not wrapping is on.
        line_quartets = line_quartets + 5'd1;
        if (line_quartets >= LINE_QUARTETS) begin
          line_quartets = 5'd0;
          if (wrap_copy) begin
            chars[4] = CHAR_CR;
            chars[5] = CHAR_LF;
            n = 6;
            full_lines_wrapped++;
          end
        end
      end
      held_bytes = 16'h0000;
      held_count = 2'd0;
      if (fin) begin
        line_quartets = 5'd0;
      end
      for (int i = 0; i < n; i++) begin
        expected_chars.push_back('{ch: chars[i], last: fin && (i == n - 1)});
      end
    end
  endtask

  // Driver: presents one queued byte at a time, with a drawn gap after each.
  always @(posedge clk_i) begin
    raw_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
        bytes_sent++;
        if (s_axis_tlast) begin
          msgs_sent++;
        end
      end
      // The bus is free once the current byte has gone, or if none was up.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          nxt = bytes_to_send.pop_front();
          s_axis_tdata <= nxt.data;
          s_axis_tlast <= nxt.fin;
          s_axis_tvalid <= 1'b1;
          send_gap = draw_wait();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every character transfer and then stalls for a drawn
  // number of cycles before it is ready again.
  always @(posedge clk_i) begin
    enc_char_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        chars_checked++;
        if (m_axis_tdata == CHAR_LF) begin
          line_breaks++;
        end
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.ch) begin
            errors++;
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.ch, m_axis_tdata);
          end
          if (m_axis_tlast !== want.last) begin
            errors++;
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.last, m_axis_tlast);
          end
        end
        recv_stall = draw_wait();
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      m_axis_tready <= (recv_stall == 0);
    end
  end

  // Watchdog: a hung block stops all transfers on both channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) begin
      bytes_to_send.push_back('{data: 8'($urandom_range(0, 255)), fin: (i == len - 1)});
    end
  endtask

  task automatic queue_fixed(input logic [7:0] data, input logic fin);
    bytes_to_send.push_back('{data: data, fin: fin});
  endtask

  // Waits until every byte has gone in and every character has come out,
  // then gives the block time to settle.
  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (bytes_to_send.size() != 0 || s_axis_tvalid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_wrap(input logic value);
    @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wrap_copy = value;
  endtask

  initial begin
    logic wrap_plan[6];
    int   queued;
    int   len;
    wrap_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short directed messages with wrapping at its reset value (off): a lone
    // byte, two bytes, one full group, and runs of full groups, some with a
    // padded tail, with all-zero, all-one and alternating bit patterns.
    queue_fixed(8'h00, 1'b1);
    queue_fixed(8'hFF, 1'b0);
    queue_fixed(8'hFF, 1'b1);
    queue_fixed(8'hFF, 1'b0);
    queue_fixed(8'hFF, 1'b0);
    queue_fixed(8'hFF, 1'b1);
    queue_fixed(8'h00, 1'b0);
    queue_fixed(8'h00, 1'b0);
    queue_fixed(8'h00, 1'b0);
    queue_fixed(8'hAA, 1'b0);
    queue_fixed(8'h55, 1'b1);
    queue_fixed(8'h80, 1'b0);
    queue_fixed(8'h01, 1'b0);
    queue_fixed(8'h7F, 1'b0);
    queue_fixed(8'hFE, 1'b1);
    queue_fixed(8'h55, 1'b0);
    queue_fixed(8'hAA, 1'b0);
    queue_fixed(8'hFF, 1'b0);
    queue_fixed(8'h00, 1'b0);
    queue_fixed(8'hFB, 1'b0);
    queue_fixed(8'hEF, 1'b1);
    drain();

    // Random phases. Message lengths are mostly short, with regular messages
    // that run past one line, end exactly on a line boundary, or hold only
    // full groups, so breaks land both mid-message and after the last quartet.
    for (int p = 0; p < 6; p++) begin
      write_wrap(wrap_plan[p]);
      case (p % 3)
        0:       pace = PACE_RANDOM;
        1:       pace = PACE_NONE;
        default: pace = PACE_SPARSE;
      endcase
      @(negedge clk_i);
      queued = 0;
      while (queued < PHASE_BYTES) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
          6, 7:             len = $urandom_range(50, 70);
          8:                len = 3 * LINE_QUARTETS;
          default:          len = 3 * $urandom_range(1, 25);
        endcase
        queue_message(len);
        queued += len;
      end
      drain();
    end

    $display("Encoded %0d bytes in %0d messages; %0d characters checked.",
             bytes_sent, msgs_sent, chars_checked);
    $display("Line breaks seen: %0d of %0d predicted, with wrapping toggled across phases.",
             line_breaks, full_lines_wrapped);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
